// ===== design/mctp_pkg.sv =====
// Shared types, constants and helper functions of the motor command text parser.
// No dependencies; every other design file imports this package.
package mctp_pkg;

    // Field widths fixed by the interface
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 3;
    localparam int DIR_W   = 2;
    localparam int BASE_W  = 16;
    localparam int SPEED_W = 7;

    // Saturation limit of the drive arithmetic before it is masked to the field
    localparam int DRIVE_WIDTH = 16;

    // Register map
    localparam logic REG_LEFT_BASE  = 1'b0;
    localparam logic REG_RIGHT_BASE = 1'b1;
    localparam logic [BASE_W-1:0] LEFT_BASE_RESET  = 16'd32768;
    localparam logic [BASE_W-1:0] RIGHT_BASE_RESET = 16'd27853;

    // Command kinds
    localparam logic [KIND_W-1:0] KIND_FORWARD  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_BACKWARD = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LEFT     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RIGHT    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_STOP     = 3'd4;

    // Motor directions
    localparam logic [DIR_W-1:0] DIR_STOPPED  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FORWARD  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_BACKWARD = 2'd2;

    // Characters of interest
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    localparam logic [SPEED_W-1:0] SPEED_MAX = 7'd100;

    // Keyword table, left aligned in 9 byte slots
    localparam int NUM_KW   = 5;
    localparam int KW_SLOTS = 9;
    localparam int KW_BITS  = KW_SLOTS * BYTE_W;
    localparam int POS_W    = 4;
    localparam int KW_STOP  = 4;

    localparam logic [KW_BITS-1:0] KW_TEXT [NUM_KW] = '{
        {"FORWARD:", 8'h00},
        "BACKWARD:",
        {"LEFT:", 32'h0},
        {"RIGHT:", 24'h0},
        {"STOP", 40'h0}
    };
    localparam logic [POS_W-1:0] KW_LEN [NUM_KW] = '{4'd8, 4'd9, 4'd5, 4'd6, 4'd4};

    // Reciprocal of 100: floor(x / 100) == (x * RECIP) >> RECIP_SHIFT for x below 2^23
    localparam int PROD_W      = BASE_W + SPEED_W;
    localparam int RECIP_W     = 24;
    localparam int RECIP_SHIFT = 30;
    localparam logic [RECIP_W-1:0] RECIP = 24'd10737419;
    localparam int SCALED_W    = PROD_W + RECIP_W;
    localparam int QUO_W       = SCALED_W - RECIP_SHIFT;
    localparam logic [32:0] DRIVE_MAX = (33'd1 << DRIVE_WIDTH) - 33'd1;

    // Queue geometry
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef enum logic [1:0] {
        PH_KEYWORD = 2'd0,
        PH_NUMBER  = 2'd1,
        PH_STOP    = 2'd2,
        PH_REJECT  = 2'd3
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] cmd_byte;
        logic              last_byte;
    } in_item_t;

    typedef struct packed {
        logic [KIND_W-1:0] command_kind;
        logic [DIR_W-1:0]  left_dir;
        logic [DIR_W-1:0]  right_dir;
        logic [BASE_W-1:0] left_drive;
        logic [BASE_W-1:0] right_drive;
    } out_item_t;

    // Parsed command handed from the front to the back
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [SPEED_W-1:0] speed;
    } cmd_t;

    function automatic logic [BYTE_W-1:0] kw_char(input logic [KW_BITS-1:0] text,
                                                  input logic [POS_W-1:0] pos);
        logic [KW_BITS-1:0] shifted;
        shifted = text << {pos, 3'b000};
        return shifted[KW_BITS-1 -: BYTE_W];
    endfunction

    function automatic logic [DIR_W-1:0] dir_left(input logic [KIND_W-1:0] kind);
        logic [DIR_W-1:0] d;
        case (kind)
            KIND_FORWARD:  d = DIR_FORWARD;
            KIND_BACKWARD: d = DIR_BACKWARD;
            KIND_LEFT:     d = DIR_BACKWARD;
            KIND_RIGHT:    d = DIR_FORWARD;
            default:       d = DIR_STOPPED;
        endcase
        return d;
    endfunction

    function automatic logic [DIR_W-1:0] dir_right(input logic [KIND_W-1:0] kind);
        logic [DIR_W-1:0] d;
        case (kind)
            KIND_FORWARD:  d = DIR_FORWARD;
            KIND_BACKWARD: d = DIR_BACKWARD;
            KIND_LEFT:     d = DIR_FORWARD;
            KIND_RIGHT:    d = DIR_BACKWARD;
            default:       d = DIR_STOPPED;
        endcase
        return d;
    endfunction

    function automatic logic [BASE_W-1:0] sat_drive(input logic [QUO_W-1:0] quo);
        logic [32:0] wide;
        wide = 33'(quo);
        if (wide > DRIVE_MAX)
        begin
            wide = DRIVE_MAX;
        end
        return wide[BASE_W-1:0];
    endfunction

endpackage

// ===== design/mctp_front.sv =====
// Front end: byte-wise keyword match and number parse, emits at most one command per packet.
// Depends on mctp_pkg.
module mctp_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  mctp_pkg::in_item_t in_item,
    output logic              emit,
    output mctp_pkg::cmd_t    cmd
);
    import mctp_pkg::*;

    phase_t              phase_reg, phase_next, tk_phase, f_phase;
    logic [POS_W-1:0]    pos_reg, pos_next, tk_pos;
    logic [NUM_KW-1:0]   live_reg, live_next, tk_live, f_live;
    logic [SPEED_W-1:0]  speed_reg, speed_next, tk_speed, f_speed;
    logic                neg_reg, neg_next, tk_neg, f_neg;
    logic                ended_reg, ended_next;

    logic [BYTE_W-1:0]   c;
    logic                is_nul;

    assign c      = in_item.cmd_byte;
    assign is_nul = (c == CH_NUL);

    // Effect of one non-NUL byte on the parser state
    always_comb
    begin
        logic [NUM_KW-1:0] still;
        logic [4:0]        pos_inc;
        logic              digit;
        logic              white;
        logic              take_digit;
        logic [10:0]       sum;

        tk_phase = phase_reg;
        tk_pos   = pos_reg;
        tk_live  = live_reg;
        tk_speed = speed_reg;
        tk_neg   = neg_reg;
        still    = '0;
        pos_inc  = 5'(pos_reg) + 5'd1;
        digit    = (c >= CH_ZERO) && (c <= CH_NINE);
        white    = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        take_digit = 1'b0;
        sum      = 11'(speed_reg) * 11'd10 + 11'(c - CH_ZERO);

        case (phase_reg)
            PH_KEYWORD:
            begin
                for (int k = 0; k < NUM_KW; k++)
                begin
                    still[k] = live_reg[k] && (pos_reg < KW_LEN[k])
                               && (kw_char(KW_TEXT[k], pos_reg) == c);
                end
                tk_live = still;
                tk_pos  = pos_inc[POS_W-1:0];
                if (still == '0)
                begin
                    tk_phase = PH_REJECT;
                end
                else
                begin
                    // Keyword lengths differ, so at most one completes here
                    for (int k = 0; k < KW_STOP; k++)
                    begin
                        if (still[k] && (5'(KW_LEN[k]) == pos_inc))
                        begin
                            tk_phase = PH_NUMBER;
                            tk_live  = NUM_KW'(1) << k;
                            tk_pos   = '0;
                            tk_speed = '0;
                            tk_neg   = 1'b0;
                        end
                    end
                    if (still[KW_STOP] && (5'(KW_LEN[KW_STOP]) == pos_inc))
                    begin
                        tk_phase = PH_STOP;
                    end
                end
            end
            PH_NUMBER:
            begin
                if (pos_reg == 4'd0)
                begin
                    if (!white)
                    begin
                        tk_pos = 4'd1;
                        if (c == CH_MINUS)
                        begin
                            tk_neg = 1'b1;
                        end
                        else if (c != CH_PLUS)
                        begin
                            take_digit = 1'b1;
                        end
                    end
                end
                else if (pos_reg == 4'd1)
                begin
                    take_digit = 1'b1;
                end
                if (take_digit)
                begin
                    if (digit)
                    begin
                        tk_speed = (sum > 11'(SPEED_MAX)) ? SPEED_MAX : sum[SPEED_W-1:0];
                    end
                    else
                    begin
                        tk_pos = 4'd2;
                    end
                end
            end
            PH_STOP:
            begin
                tk_phase = PH_REJECT;
            end
            default:
            begin
                tk_phase = phase_reg;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        live_next  = live_reg;
        speed_next = speed_reg;
        neg_next   = neg_reg;
        ended_next = ended_reg;
        if (accept)
        begin
            if (!ended_reg)
            begin
                if (is_nul)
                begin
                    ended_next = 1'b1;
                end
                else
                begin
                    phase_next = tk_phase;
                    pos_next   = tk_pos;
                    live_next  = tk_live;
                    speed_next = tk_speed;
                    neg_next   = tk_neg;
                end
            end
            if (in_item.last_byte)
            begin
                phase_next = PH_KEYWORD;
                pos_next   = '0;
                live_next  = '1;
                speed_next = '0;
                neg_next   = 1'b0;
                ended_next = 1'b0;
            end
        end
    end

    // Outputs: the command at the end of the string
    always_comb
    begin
        f_phase = is_nul ? phase_reg : tk_phase;
        f_live  = is_nul ? live_reg  : tk_live;
        f_speed = is_nul ? speed_reg : tk_speed;
        f_neg   = is_nul ? neg_reg   : tk_neg;

        emit = accept && !ended_reg && (is_nul || in_item.last_byte)
               && ((f_phase == PH_STOP) || (f_phase == PH_NUMBER));

        if (f_phase == PH_STOP)
        begin
            cmd.kind  = KIND_STOP;
            cmd.speed = '0;
        end
        else
        begin
            if (f_live[0])
            begin
                cmd.kind = KIND_FORWARD;
            end
            else if (f_live[1])
            begin
                cmd.kind = KIND_BACKWARD;
            end
            else if (f_live[2])
            begin
                cmd.kind = KIND_LEFT;
            end
            else
            begin
                cmd.kind = KIND_RIGHT;
            end
            cmd.speed = f_neg ? '0 : f_speed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_KEYWORD;
            pos_reg   <= '0;
            live_reg  <= '1;
            speed_reg <= '0;
            neg_reg   <= 1'b0;
            ended_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            live_reg  <= live_next;
            speed_reg <= speed_next;
            neg_reg   <= neg_next;
            ended_reg <= ended_next;
        end
    end

endmodule

// ===== design/mctp_queue.sv =====
// Short command queue between the parsing front and the drive back end.
// Depends on mctp_pkg.
module mctp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mctp_pkg::cmd_t din,
    output logic           full,
    input  logic           pop,
    output mctp_pkg::cmd_t dout,
    output logic           empty
);
    import mctp_pkg::*;

    cmd_t               mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== design/mctp_back.sv =====
// Back end: scales the base drives by speed/100 in two multiply stages, then queues results.
// Depends on mctp_pkg.
module mctp_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [mctp_pkg::BASE_W-1:0]   left_base,
    input  logic [mctp_pkg::BASE_W-1:0]   right_base,
    input  logic                          cmd_empty,
    input  mctp_pkg::cmd_t                cmd,
    output logic                          cmd_pop,
    output logic                          empty,
    input  logic                          pop,
    output mctp_pkg::out_item_t           result
);
    import mctp_pkg::*;

    // Stage 1: base * speed
    logic                 v1_reg;
    logic [KIND_W-1:0]    kind1_reg;
    logic [PROD_W-1:0]    prod_l_reg, prod_r_reg;
    // Stage 2: product * reciprocal of 100
    logic                 v2_reg;
    logic [KIND_W-1:0]    kind2_reg;
    logic [SCALED_W-1:0]  scaled_l_reg, scaled_r_reg;

    out_item_t            fifo_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg, count_next;
    logic [Q_CNT_W-1:0]   committed;
    logic                 fifo_pop;
    out_item_t            fifo_in;

    // Issue only when the result queue has room for everything in flight
    assign committed = count_reg + Q_CNT_W'(v1_reg) + Q_CNT_W'(v2_reg);
    assign cmd_pop   = !cmd_empty && (committed < Q_CNT_W'(Q_DEPTH));

    assign empty    = (count_reg == '0);
    assign fifo_pop = pop && !empty;
    assign result   = fifo_mem[rd_ptr_reg];

    always_comb
    begin
        fifo_in.command_kind = kind2_reg;
        fifo_in.left_dir     = dir_left(kind2_reg);
        fifo_in.right_dir    = dir_right(kind2_reg);
        fifo_in.left_drive   = sat_drive(scaled_l_reg[SCALED_W-1:RECIP_SHIFT]);
        fifo_in.right_drive  = sat_drive(scaled_r_reg[SCALED_W-1:RECIP_SHIFT]);
        count_next = count_reg + Q_CNT_W'(v2_reg) - Q_CNT_W'(fifo_pop);
    end

    always_ff @(posedge clk)
    begin
        kind1_reg    <= cmd.kind;
        prod_l_reg   <= PROD_W'(left_base) * PROD_W'(cmd.speed);
        prod_r_reg   <= PROD_W'(right_base) * PROD_W'(cmd.speed);
        kind2_reg    <= kind1_reg;
        scaled_l_reg <= SCALED_W'(prod_l_reg) * SCALED_W'(RECIP);
        scaled_r_reg <= SCALED_W'(prod_r_reg) * SCALED_W'(RECIP);
        if (v2_reg)
        begin
            fifo_mem[wr_ptr_reg] <= fifo_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            v1_reg     <= cmd_pop;
            v2_reg     <= v1_reg;
            wr_ptr_reg <= v2_reg ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
            rd_ptr_reg <= fifo_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== design/motor_command_text_parser.sv =====
// Motor command text parser: top level with the base drive registers.
// Depends on mctp_pkg, mctp_front, mctp_queue and mctp_back.
// Throughput: one byte beat per cycle unless the command queue is full; one result beat per cycle out
// of the result queue. A result shows (empty low) once the command of its ending byte has passed the
// command queue and the two multiply stages of the drive scaler.
// Reset: asynchronous, active low; parser idle, queues empty, registers at their defaults.
module motor_command_text_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    // Byte input, queue style
    input  logic                          push,
    input  mctp_pkg::in_item_t            in_item,
    output logic                          full,
    // Result output, queue style
    input  logic                          pop,
    output mctp_pkg::out_item_t           result,
    output logic                          empty,
    // Register write port
    input  logic                          cfg_write,
    input  logic                          cfg_index,
    input  logic [mctp_pkg::BASE_W-1:0]   cfg_data
);
    import mctp_pkg::*;

    logic [BASE_W-1:0] left_base_reg;
    logic [BASE_W-1:0] right_base_reg;

    logic accept;
    logic emit;
    cmd_t front_cmd;
    cmd_t queue_cmd;
    logic queue_full;
    logic queue_empty;
    logic queue_pop;

    // Hold off every byte while the command queue is full: any byte may end a packet
    assign full   = queue_full;
    assign accept = push && !queue_full;

    // Base drive registers; the user must write them only while the block is idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_base_reg  <= LEFT_BASE_RESET;
            right_base_reg <= RIGHT_BASE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_LEFT_BASE:  left_base_reg  <= cfg_data;
                REG_RIGHT_BASE: right_base_reg <= cfg_data;
                default:        left_base_reg  <= left_base_reg;
            endcase
        end
    end

    // Front: classify each byte, emit a command when a packet ends
    mctp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_item (in_item),
        .emit    (emit),
        .cmd     (front_cmd)
    );

    // Decouple parsing from the drive arithmetic
    mctp_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (emit),
        .din   (front_cmd),
        .full  (queue_full),
        .pop   (queue_pop),
        .dout  (queue_cmd),
        .empty (queue_empty)
    );

    // Back: directions, scaled drives and the result queue
    mctp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .left_base  (left_base_reg),
        .right_base (right_base_reg),
        .cmd_empty  (queue_empty),
        .cmd        (queue_cmd),
        .cmd_pop    (queue_pop),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

endmodule

// ===== tb/sv/motor_command_text_parser_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for motor_command_text_parser: directed packet table, then random packets.
// Depends on mctp_pkg and the design files; results are checked against an in-bench parser copy or typed rows.
module motor_command_text_parser_test;
    import mctp_pkg::*;

    // Give up well past the slowest legal run, even with the heaviest idling
    localparam int CYCLE_LIMIT  = 200000;
    // Number of random phases, and how long the receiver holds off in the pressure phase
    localparam int NUM_PHASES   = 5;
    localparam int HOLD_CYCLES  = 300;
    // Settling time once the last result is in, with plenty of margin over the pipeline
    localparam int SETTLE_CYCLES = 8;
    localparam int PROBE_ROWS   = 21;

    typedef logic [BYTE_W-1:0] byte_q_t [$];

    // How a directed row is checked: by the parser copy, expecting nothing, or a typed result
    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_SILENT,
        ROW_TYPED
    } row_mode_t;

    typedef struct {
        string     text;
        row_mode_t mode;
        out_item_t want;
    } probe_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    in_item_t    in_item = '0;
    logic        full;
    logic        pop = 1'b0;
    out_item_t   result;
    logic        empty;
    logic        cfg_write = 1'b0;
    logic        cfg_index = 1'b0;
    logic [BASE_W-1:0] cfg_data = '0;

    motor_command_text_parser i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .in_item   (in_item),
        .full      (full),
        .pop       (pop),
        .result    (result),
        .empty     (empty),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------
    // Shadow of the parser: keyword matcher, number reader and registers
    // ------------------------------------------------------------------
    string kw_words [5] = '{"FORWARD:", "BACKWARD:", "LEFT:", "RIGHT:", "STOP"};
    // Motor directions per command kind, forward / backward / left / right
    logic [DIR_W-1:0] lmotor_dir [4] = '{DIR_FORWARD, DIR_BACKWARD, DIR_BACKWARD, DIR_FORWARD};
    logic [DIR_W-1:0] rmotor_dir [4] = '{DIR_FORWARD, DIR_BACKWARD, DIR_FORWARD, DIR_BACKWARD};
    logic [BYTE_W-1:0] white_set [6] = '{CH_SPACE, CH_TAB, 8'h0A, 8'h0B, 8'h0C, CH_CR};

    logic [POS_W-1:0]   sh_pos;
    logic [NUM_KW-1:0]  sh_live;
    phase_t             sh_phase;
    logic [SPEED_W-1:0] sh_speed;
    logic               sh_neg;
    logic               sh_ended;
    logic [BASE_W-1:0]  left_base;
    logic [BASE_W-1:0]  right_base;

    // Commands the block still owes us, oldest first
    out_item_t   queued_commands [$];
    byte_q_t     packet_bytes;
    out_item_t   oldest;
    int          mismatches = 0;
    int          beat_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic        hold_pop = 1'b0;
    int unsigned cycle_count = 0;

    // Directed packets; '@' stands for a NUL byte. Typed rows assume the reset base drives.
    probe_row_t probe_table [PROBE_ROWS] = '{
        '{"STOP", ROW_TYPED, {KIND_STOP, DIR_STOPPED, DIR_STOPPED, 16'd0, 16'd0}},
        '{"FORWARD:100", ROW_TYPED,
          {KIND_FORWARD, DIR_FORWARD, DIR_FORWARD, LEFT_BASE_RESET, RIGHT_BASE_RESET}},
        '{"BACKWARD:0", ROW_TYPED, {KIND_BACKWARD, DIR_BACKWARD, DIR_BACKWARD, 16'd0, 16'd0}},
        // negative speed counts as zero
        '{"LEFT:-5", ROW_TYPED, {KIND_LEFT, DIR_BACKWARD, DIR_FORWARD, 16'd0, 16'd0}},
        // prefix with no number at all
        '{"RIGHT:", ROW_TYPED, {KIND_RIGHT, DIR_FORWARD, DIR_BACKWARD, 16'd0, 16'd0}},
        // leading zeros, then a value far past the ceiling
        '{"RIGHT:0000099999", ROW_TYPED,
          {KIND_RIGHT, DIR_FORWARD, DIR_BACKWARD, LEFT_BASE_RESET, RIGHT_BASE_RESET}},
        '{"FORW", ROW_SILENT, '0},
        '{"STOPX", ROW_SILENT, '0},
        // NUL straight after STOP ends the string, trailing bytes ignored
        '{"STOP@XY", ROW_TYPED, {KIND_STOP, DIR_STOPPED, DIR_STOPPED, 16'd0, 16'd0}},
        '{"@RIGHT:7", ROW_SILENT, '0},
        '{"\377\200LEFT:5", ROW_SILENT, '0},
        '{"forward:10", ROW_SILENT, '0},
        '{"STO@P", ROW_SILENT, '0},
        '{"FORWARD:  +50x7", ROW_PREDICT, '0},
        '{"LEFT:\t\n\013\014\r 42", ROW_PREDICT, '0},
        '{"BACKWARD:-", ROW_PREDICT, '0},
        '{"FORWARD:+-3", ROW_PREDICT, '0},
        '{"RIGHT:50 12", ROW_PREDICT, '0},
        '{"FORWARD:1@2", ROW_PREDICT, '0},
        '{"STOP@", ROW_PREDICT, '0},
        '{"BACKWARD:37", ROW_PREDICT, '0}
    };

    task automatic clear_shadow();
        sh_pos   = '0;
        sh_live  = '1;
        sh_phase = PH_KEYWORD;
        sh_speed = '0;
        sh_neg   = 1'b0;
        sh_ended = 1'b0;
    endtask

    function automatic logic [BASE_W-1:0] scale_base(input logic [BASE_W-1:0] base,
                                                     input int speed);
        longint v;
        v = (longint'(base) * speed) / 100;
        if (v > ((longint'(1) << DRIVE_WIDTH) - 1))
        begin
            v = (longint'(1) << DRIVE_WIDTH) - 1;
        end
        return BASE_W'(v);
    endfunction

    // Advance the shadow parser by one non-NUL byte
    task automatic advance_parser(input logic [BYTE_W-1:0] c);
        int  pos;
        int  k;
        int  v;
        bit  done;
        bit  is_digit;
        bit  is_white;
        bit  skip;
        if (sh_phase == PH_KEYWORD)
        begin
            pos = sh_pos;
            // Drop every keyword that this byte breaks
            for (k = 0; k < NUM_KW; k++)
            begin
                if (sh_live[k] && !(pos < kw_words[k].len() && kw_words[k][pos] == c))
                begin
                    sh_live[k] = 1'b0;
                end
            end
            sh_pos = POS_W'(pos + 1);
            if (sh_live == '0)
            begin
                sh_phase = PH_REJECT;
            end
            else
            begin
                done = 1'b0;
                for (k = 0; k < NUM_KW; k++)
                begin
                    if (!done && sh_live[k] && kw_words[k].len() == pos + 1)
                    begin
                        done = 1'b1;
                        if (k < KW_STOP)
                        begin
                            sh_phase = PH_NUMBER;
                            sh_live  = NUM_KW'(1 << k);
                            sh_pos   = '0;
                            sh_speed = '0;
                            sh_neg   = 1'b0;
                        end
                        else
                        begin
                            sh_phase = PH_STOP;
                        end
                    end
                end
            end
        end
        else if (sh_phase == PH_NUMBER)
        begin
            // Position 0 skips white space and takes a sign, 1 reads digits, 2 is done
            is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
            is_white = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
            skip = 1'b0;
            if (sh_pos == 0)
            begin
                if (is_white)
                begin
                    skip = 1'b1;
                end
                else
                begin
                    sh_pos = POS_W'(1);
                    if (c == CH_PLUS)
                    begin
                        skip = 1'b1;
                    end
                    else if (c == CH_MINUS)
                    begin
                        sh_neg = 1'b1;
                        skip = 1'b1;
                    end
                end
            end
            if (!skip && sh_pos == 1)
            begin
                if (is_digit)
                begin
                    v = int'(sh_speed) * 10 + int'(c - CH_ZERO);
                    sh_speed = (v > SPEED_MAX) ? SPEED_MAX : SPEED_W'(v);
                end
                else
                begin
                    sh_pos = POS_W'(2);
                end
            end
        end
        else if (sh_phase == PH_STOP)
        begin
            // anything but NUL after STOP spoils it
            sh_phase = PH_REJECT;
        end
    endtask

    // End of string: a complete STOP or a prefixed command gives one result
    task automatic close_command(output bit hit, output out_item_t r);
        int kind;
        int speed;
        r = '0;
        hit = 1'b0;
        if (sh_phase == PH_STOP)
        begin
            hit = 1'b1;
            r.command_kind = KIND_STOP;
        end
        else if (sh_phase == PH_NUMBER)
        begin
            hit = 1'b1;
            kind = 0;
            while (kind < 3 && !sh_live[kind])
            begin
                kind++;
            end
            speed = sh_neg ? 0 : int'(sh_speed);
            r.command_kind = KIND_W'(kind);
            r.left_dir     = lmotor_dir[kind];
            r.right_dir    = rmotor_dir[kind];
            r.left_drive   = scale_base(left_base, speed);
            r.right_drive  = scale_base(right_base, speed);
        end
    endtask

    task automatic track_byte(input in_item_t it, output bit hit, output out_item_t r);
        hit = 1'b0;
        r = '0;
        // Bytes after a NUL are ignored up to the end of the packet
        if (!sh_ended)
        begin
            if (it.cmd_byte == CH_NUL)
            begin
                close_command(hit, r);
                sh_ended = 1'b1;
            end
            else
            begin
                advance_parser(it.cmd_byte);
                if (it.last_byte)
                begin
                    close_command(hit, r);
                end
            end
        end
        if (it.last_byte)
        begin
            clear_shadow();
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Append the first n characters of s, turning '@' into NUL
    task automatic push_text(input string s, input int n);
        int i;
        logic [BYTE_W-1:0] ch;
        for (i = 0; i < n; i++)
        begin
            ch = s[i];
            packet_bytes.push_back((ch == "@") ? CH_NUL : ch);
        end
    endtask

    // Offer one beat, idling first at random; return once it has been taken
    task automatic send_beat(input in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        beat_count++;
    endtask

    // Send packet_bytes as one packet and queue what it should produce
    task automatic send_packet(input row_mode_t mode, input out_item_t want);
        int        i;
        in_item_t  it;
        bit        hit;
        bit        placed;
        out_item_t r;
        placed = 1'b0;
        for (i = 0; i < packet_bytes.size(); i++)
        begin
            it.cmd_byte  = packet_bytes[i];
            it.last_byte = (i == packet_bytes.size() - 1);
            send_beat(it);
            track_byte(it, hit, r);
            if (hit && mode == ROW_PREDICT)
            begin
                queued_commands.push_back(r);
            end
            else if (hit && mode == ROW_TYPED && !placed)
            begin
                queued_commands.push_back(want);
                placed = 1'b1;
            end
        end
        // A typed row whose end the shadow missed still owes its result
        if (mode == ROW_TYPED && !placed)
        begin
            queued_commands.push_back(want);
        end
    endtask

    // Build a random packet: mostly well-formed commands, some broken ones and noise
    task automatic build_packet();
        int form;
        int w;
        int n;
        int r;
        packet_bytes = {};
        form = $urandom_range(99);
        if (form < 65)
        begin
            w = $urandom_range(3);
            push_text(kw_words[w], kw_words[w].len());
            repeat ($urandom_range(2))
            begin
                packet_bytes.push_back(white_set[$urandom_range(5)]);
            end
            r = $urandom_range(5);
            if (r == 0)
            begin
                packet_bytes.push_back(CH_PLUS);
            end
            else if (r == 1)
            begin
                packet_bytes.push_back(CH_MINUS);
            end
            // mostly short numbers, now and then one long enough to saturate
            n = ($urandom_range(9) == 0) ? $urandom_range(7, 4) : $urandom_range(3);
            repeat (n)
            begin
                packet_bytes.push_back(CH_ZERO + BYTE_W'($urandom_range(9)));
            end
            if ($urandom_range(3) == 0)
            begin
                packet_bytes.push_back(BYTE_W'($urandom_range(255, 1)));
            end
            if ($urandom_range(5) == 0)
            begin
                packet_bytes.push_back(CH_NUL);
                repeat ($urandom_range(2))
                begin
                    packet_bytes.push_back(BYTE_W'($urandom_range(255)));
                end
            end
        end
        else if (form < 78)
        begin
            push_text(kw_words[KW_STOP], kw_words[KW_STOP].len());
            r = $urandom_range(3);
            if (r == 1)
            begin
                packet_bytes.push_back(BYTE_W'($urandom_range(255, 1)));
            end
            else if (r == 2)
            begin
                packet_bytes.push_back(CH_NUL);
                packet_bytes.push_back(BYTE_W'($urandom_range(255)));
            end
        end
        else if (form < 90)
        begin
            // keyword, possibly truncated or corrupted, sometimes followed by a digit
            w = $urandom_range(NUM_KW - 1);
            n = $urandom_range(kw_words[w].len(), 1);
            push_text(kw_words[w], n);
            if ($urandom_range(1))
            begin
                packet_bytes[$urandom_range(n - 1)] = BYTE_W'($urandom_range(255, 1));
            end
            if ($urandom_range(1))
            begin
                packet_bytes.push_back(CH_ZERO + BYTE_W'($urandom_range(9)));
            end
        end
        else
        begin
            repeat ($urandom_range(6, 1))
            begin
                packet_bytes.push_back(BYTE_W'($urandom_range(255)));
            end
        end
    endtask

    // Write both base drives; only called with the block idle
    task automatic write_bases(input logic [BASE_W-1:0] lb, input logic [BASE_W-1:0] rb);
        cfg_write <= 1'b1;
        cfg_index <= REG_LEFT_BASE;
        cfg_data  <= lb;
        @(posedge clk);
        cfg_index <= REG_RIGHT_BASE;
        cfg_data  <= rb;
        @(posedge clk);
        cfg_write <= 1'b0;
        left_base  = lb;
        right_base = rb;
    endtask

    // Hold the input until every queued command is out, then let the pipe settle
    task automatic drain_results();
        push <= 1'b0;
        while (queued_commands.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: pop at random, compare each beat with the oldest command
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input longint got, input longint want);
        if (got != want)
        begin
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (queued_commands.size() == 0)
            begin
                report_mismatch($sformatf("result beat with nothing queued, kind %0d",
                                          result.command_kind));
            end
            else
            begin
                oldest = queued_commands.pop_front();
                compare_field("command_kind", result.command_kind, oldest.command_kind);
                compare_field("left_dir", result.left_dir, oldest.left_dir);
                compare_field("right_dir", result.right_dir, oldest.right_dir);
                compare_field("left_drive", result.left_drive, oldest.left_drive);
                compare_field("right_drive", result.right_drive, oldest.right_drive);
            end
        end
        pop <= !hold_pop && ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    // Per random phase: beats, sender idle and receiver stall percentages.
    // The last phase is the pressure phase with the long receiver hold-off; it runs
    // long enough to fill both queues and push back on the byte input.
    int phase_beats [NUM_PHASES] = '{80, 80, 80, 80, 140};
    int phase_idle  [NUM_PHASES] = '{0, 87, 0, 30, 0};
    int phase_stall [NUM_PHASES] = '{0, 0, 87, 30, 0};

    initial
    begin
        int p;
        int i;
        int beat_goal;
        logic [BASE_W-1:0] lb;
        logic [BASE_W-1:0] rb;
        clear_shadow();
        left_base  = LEFT_BASE_RESET;
        right_base = RIGHT_BASE_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table at the reset base drives, no idling
        for (i = 0; i < PROBE_ROWS; i++)
        begin
            packet_bytes = {};
            push_text(probe_table[i].text, probe_table[i].text.len());
            send_packet(probe_table[i].mode, probe_table[i].want);
        end
        drain_results();

        beat_count = 0;
        beat_goal  = 0;
        for (p = 0; p < NUM_PHASES; p++)
        begin
            // Extremes first, then random settings with the defaults in between
            case (p)
                0:
                begin
                    lb = 16'hFFFF;
                    rb = 16'h0000;
                end
                1:
                begin
                    lb = 16'h0000;
                    rb = 16'hFFFF;
                end
                3:
                begin
                    lb = LEFT_BASE_RESET;
                    rb = RIGHT_BASE_RESET;
                end
                default:
                begin
                    lb = BASE_W'($urandom_range(65535));
                    rb = BASE_W'($urandom_range(65535));
                end
            endcase
            write_bases(lb, rb);
            send_idle_pct   = phase_idle[p];
            recv_stall_pct <= phase_stall[p];
            if (p == NUM_PHASES - 1)
            begin
                // Starve the output for a long stretch so the result queue fills
                // and the block pushes back on the byte input
                fork
                    begin
                        hold_pop <= 1'b1;
                        repeat (HOLD_CYCLES) @(posedge clk);
                        hold_pop <= 1'b0;
                    end
                join_none
            end
            beat_goal += phase_beats[p];
            while (beat_count < beat_goal)
            begin
                build_packet();
                send_packet(ROW_PREDICT, '0);
            end
            drain_results();
        end

        if (mismatches == 0 && queued_commands.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/mctp_pkg.sv
design/mctp_front.sv
design/mctp_queue.sv
design/mctp_back.sv
design/motor_command_text_parser.sv
tb/sv/motor_command_text_parser_test.sv
